// ===== rtl/sorted_alarm_timer_queue_defines.svh =====
// Assertion macros for the sorted alarm timer queue checker.
`ifndef SORTED_ALARM_TIMER_QUEUE_DEFINES_SVH
`define SORTED_ALARM_TIMER_QUEUE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define SATQ_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define SATQ_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/satq_pkg.sv =====
// Shared types and constants of the sorted alarm timer queue.
package satq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_POP    = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] expiry;
      logic [31:0] session;
      logic [15:0] alarm;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      logic [31:0] expiry;
      logic [31:0] session;
      logic [15:0] alarm;
   } cell_ctl_type;

endpackage

// ===== rtl/sorted_alarm_timer_queue.sv =====
// Top level of the sorted alarm timer queue: control sequencer and chain of slot cells.
// Add and pop: the request is registered, run in the EXEC state, and its result registered in EMIT.
// Cancel and remove-session also pass through a SCAN state over the N alarms held:
// the whole chain rotates once through the head cell, one entry per cycle.
// A new request is taken only while idle or while the previous result is being emitted.
// Reset (synchronous): clears slot valid bits, the state, the entry count and the response valid bit.
module sorted_alarm_timer_queue
   import satq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // now[31:0], delay[63:32], session[95:64], alarm_id[111:96]
   input  logic [1:0]   req_tuser,   // cmd[1:0]
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // out_session[31:0], out_alarm[47:32], out_expiry[79:48],
                                     // entries_held[84:80], zero pad[87:85]
   output logic [1:0]   rsp_tuser    // status[1:0]
);

   // Request capture
   cmd_type     cmd_ff,   cmd_in;
   logic [31:0] now_ff,   now_in;
   logic [31:0] exp_ff,   exp_in;
   logic [31:0] sess_ff,  sess_in;
   logic [15:0] alarm_ff, alarm_in;

   // Control
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_left_ff, scan_left_in;
   logic             found_ff, found_in;

   // Result staging
   status_type  res_status_ff, res_status_in;
   logic [31:0] res_sess_ff,   res_sess_in;
   logic [15:0] res_alarm_ff,  res_alarm_in;
   logic [31:0] res_exp_ff,    res_exp_in;

   // Response register
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [87:0] rsp_data_ff,   rsp_data_in;
   logic [1:0]  rsp_user_ff,   rsp_user_in;

   logic        out_free;
   logic        accept;
   logic [32:0] sum;
   logic        drop;

   cell_ctl_type cell_ctl;
   entry_type    cell_q     [CAPACITY];
   entry_type    left_q     [CAPACITY];
   entry_type    right_q    [CAPACITY];
   logic         after_q    [CAPACITY];
   logic         left_after [CAPACITY];
   entry_type    empty_entry;

   assign empty_entry = '{valid: 1'b0, expiry: '0, session: '0, alarm: '0};

   // Handshake: the response register frees when empty or being drained.
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_EMIT) && out_free);
   assign accept     = req_tvalid && req_tready;

   // Saturating expiry, worked out as the transaction is taken.
   assign sum = {1'b0, req_tdata[31:0]} + {1'b0, req_tdata[63:32]};

   always_comb begin
      cmd_in   = cmd_ff;
      now_in   = now_ff;
      exp_in   = exp_ff;
      sess_in  = sess_ff;
      alarm_in = alarm_ff;
      if (accept) begin
         cmd_in   = cmd_type'(req_tuser);
         now_in   = req_tdata[31:0];
         exp_in   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         sess_in  = req_tdata[95:64];
         alarm_in = req_tdata[111:96];
      end
   end

   // Head entry decides cancel and remove-session drops during the rotation.
   always_comb begin
      drop = 1'b0;
      if (cell_q[0].session == sess_ff) begin
         if (cmd_ff == CMD_REMOVE) begin
            drop = 1'b1;
         end else if (cell_q[0].alarm == alarm_ff && !found_ff) begin
            drop = 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((cmd_ff == CMD_CANCEL || cmd_ff == CMD_REMOVE) && count_ff != '0) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (scan_left_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: cell commands, count, result staging
   always_comb begin
      cell_ctl.op      = CELL_HOLD;
      cell_ctl.expiry  = exp_ff;
      cell_ctl.session = sess_ff;
      cell_ctl.alarm   = alarm_ff;
      count_in         = count_ff;
      scan_left_in     = scan_left_ff;
      found_in         = found_ff;
      res_status_in    = res_status_ff;
      res_sess_in      = res_sess_ff;
      res_alarm_in     = res_alarm_ff;
      res_exp_in       = res_exp_ff;
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rsp_user_in      = rsp_user_ff;

      case (state_ff)
         ST_EXEC: begin
            res_status_in = STATUS_DONE;
            res_sess_in   = '0;
            res_alarm_in  = '0;
            res_exp_in    = '0;
            scan_left_in  = count_ff;
            found_in      = 1'b0;
            case (cmd_ff)
               CMD_ADD: begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     cell_ctl.op = CELL_INSERT;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               CMD_CANCEL: begin
                  res_status_in = STATUS_NONE;
               end
               CMD_POP: begin
                  if (cell_q[0].valid && cell_q[0].expiry < now_ff) begin
                     cell_ctl.op  = CELL_SHIFT;
                     count_in     = count_ff - CNT_W'(1);
                     res_sess_in  = cell_q[0].session;
                     res_alarm_in = cell_q[0].alarm;
                     res_exp_in   = cell_q[0].expiry;
                  end else begin
                     res_status_in = STATUS_NONE;
                  end
               end
               CMD_REMOVE: begin
                  res_status_in = STATUS_DONE;
               end
               default: begin
                  res_status_in = STATUS_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            scan_left_in = scan_left_ff - CNT_W'(1);
            if (drop) begin
               cell_ctl.op = CELL_SHIFT;
               count_in    = count_ff - CNT_W'(1);
               if (cmd_ff == CMD_CANCEL) begin
                  found_in      = 1'b1;
                  res_status_in = STATUS_DONE;
                  res_sess_in   = cell_q[0].session;
               end
            end else begin
               cell_ctl.op = CELL_ROTATE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {3'b000, 5'(count_ff), res_exp_ff, res_alarm_ff, res_sess_ff};
               rsp_user_in   = 2'(res_status_ff);
            end
         end
         default: begin
            cell_ctl.op = CELL_HOLD;
         end
      endcase
   end

   // Cell chain: each slot sees its left and right neighbors and the head.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_q[i]     = empty_entry;
         assign left_after[i] = 1'b0;
      end else begin : g_mid
         assign left_q[i]     = cell_q[i-1];
         assign left_after[i] = after_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_q[i] = empty_entry;
      end else begin : g_inner
         assign right_q[i] = cell_q[i+1];
      end

      satq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .is_head     (i == 0),
         .ctl         (cell_ctl),
         .left_entry  (left_q[i]),
         .left_after  (left_after[i]),
         .right_entry (right_q[i]),
         .head_entry  (cell_q[0]),
         .entry       (cell_q[i]),
         .after_new   (after_q[i])
      );
   end

   // Control state: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      exp_ff        <= exp_in;
      sess_ff       <= sess_in;
      alarm_ff      <= alarm_in;
      scan_left_ff  <= scan_left_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_sess_ff   <= res_sess_in;
      res_alarm_ff  <= res_alarm_in;
      res_exp_ff    <= res_exp_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/satq_cell.sv =====
// One slot of the sorted alarm chain: holds an entry and trades with its neighbors.
module satq_cell
   import satq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         is_head,
   input  cell_ctl_type ctl,
   input  entry_type    left_entry,
   input  logic         left_after,
   input  entry_type    right_entry,
   input  entry_type    head_entry,
   output entry_type    entry,
   output logic         after_new
);

   entry_type entry_ff;
   entry_type entry_in;

   // Set when the new alarm belongs at or before this slot.
   assign after_new = !entry_ff.valid ||
                      (is_head ? (entry_ff.expiry > ctl.expiry)
                               : (entry_ff.expiry >= ctl.expiry));

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (left_after) begin
               entry_in = left_entry;
            end else if (after_new) begin
               entry_in.valid   = 1'b1;
               entry_in.expiry  = ctl.expiry;
               entry_in.session = ctl.session;
               entry_in.alarm   = ctl.alarm;
            end
         end
         CELL_SHIFT: begin
            entry_in = right_entry;
         end
         CELL_ROTATE: begin
            // The last occupied slot takes the recirculated head.
            if (entry_ff.valid && !right_entry.valid) begin
               entry_in = head_entry;
            end else begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/satq_checker.sv =====
// Port-level assertions for the sorted alarm timer queue, bound to the top level.
`include "sorted_alarm_timer_queue_defines.svh"

module satq_checker
   import satq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [111:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [87:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `SATQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")
   `SATQ_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `SATQ_ASSERT_ALWAYS(a_count_range, !rsp_tvalid || rsp_tdata[84:80] <= 5'(CAPACITY), "entry count too large")
   `SATQ_ASSERT_ALWAYS(a_status_code, !rsp_tvalid || rsp_tuser != 2'd3, "undefined status code")
   `SATQ_ASSERT_ALWAYS(a_full_result, !rsp_tvalid || rsp_tuser != STATUS_FULL || (rsp_tdata[84:80] == 5'(CAPACITY) && rsp_tdata[79:0] == '0), "full result inconsistent")

endmodule

bind sorted_alarm_timer_queue satq_checker u_satq_checker (.*);

// ===== dv/tb_sorted_alarm_timer_queue.sv =====
// Self-checking testbench for the sorted alarm timer queue: directed table, then random traffic.
module tb_sorted_alarm_timer_queue;
   import satq_pkg::*;

   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_ITEMS     = 1460;
   localparam int QUIET_ITEMS      = 150;      // final random items sent without any idling
   localparam int LONG_HOLD_AT     = 3000;     // receiver cycle at which the long hold-off starts
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT      = 5000;
   localparam int SETTLE_CYCLES    = CAPACITY + 6;   // outlasts the longest scan, over a full table
   localparam int TIMEOUT_CYCLES   = 200_000;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] now;
      logic [31:0] delay;
      logic [31:0] session;
      logic [15:0] alarm;
   } alarm_request_type;

   typedef struct packed {
      status_type       status;
      logic [31:0]      session;
      logic [15:0]      alarm;
      logic [31:0]      expiry;
      logic [CNT_W-1:0] held;
   } alarm_result_type;

   // One table row: a request sent 'copies' times in a row; when 'typed' is set the
   // response is compared with the result typed here instead of the predicted one.
   typedef struct packed {
      alarm_request_type request;
      logic [4:0]        copies;
      logic              typed;
      alarm_result_type  result;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 24;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // empty table: nothing to pop, nothing to cancel, a removal still reports done
      '{'{CMD_POP, 32'd0, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b1,
        '{STATUS_NONE, 32'd0, 16'd0, 32'd0, 5'd0}},
      '{'{CMD_CANCEL, 32'd0, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b1,
        '{STATUS_NONE, 32'd0, 16'd0, 32'd0, 5'd0}},
      '{'{CMD_REMOVE, 32'd0, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b1,
        '{STATUS_DONE, 32'd0, 16'd0, 32'd0, 5'd0}},
      // all ones: the expiry sum overflows and saturates
      '{'{CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 5'd1, 1'b1,
        '{STATUS_DONE, 32'd0, 16'd0, 32'd0, 5'd1}},
      // three alarms due at 100: the later two tie with the head and go second
      '{'{CMD_ADD, 32'd100, 32'd0, 32'd1, 16'd1}, 5'd1, 1'b0, '0},
      '{'{CMD_ADD, 32'd50, 32'd50, 32'd2, 16'd2}, 5'd1, 1'b0, '0},
      '{'{CMD_ADD, 32'd0, 32'd100, 32'd3, 16'd3}, 5'd1, 1'b0, '0},
      // head due exactly now is not yet expired
      '{'{CMD_POP, 32'd100, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b1,
        '{STATUS_NONE, 32'd0, 16'd0, 32'd0, 5'd4}},
      '{'{CMD_POP, 32'd101, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b0, '0},
      '{'{CMD_POP, 32'd101, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b0, '0},
      // new earliest alarm becomes head, then cancel it; cancel a missing one
      '{'{CMD_ADD, 32'd10, 32'd5, 32'd2, 16'd7}, 5'd1, 1'b0, '0},
      '{'{CMD_CANCEL, 32'd0, 32'd0, 32'd2, 16'd7}, 5'd1, 1'b0, '0},
      '{'{CMD_CANCEL, 32'd0, 32'd0, 32'd2, 16'd9}, 5'd1, 1'b1,
        '{STATUS_NONE, 32'd0, 16'd0, 32'd0, 5'd2}},
      // two adjacent alarms of one session, dropped by a single removal
      '{'{CMD_ADD, 32'd0, 32'd0, 32'd5, 16'd1}, 5'd1, 1'b0, '0},
      '{'{CMD_ADD, 32'd0, 32'd1, 32'd5, 16'd2}, 5'd1, 1'b0, '0},
      '{'{CMD_REMOVE, 32'd0, 32'd0, 32'd5, 16'd0}, 5'd1, 1'b0, '0},
      '{'{CMD_REMOVE, 32'd0, 32'd0, 32'd9, 16'd0}, 5'd1, 1'b0, '0},
      // fill the table, then one add too many
      '{'{CMD_ADD, 32'd200, 32'd7, 32'd6, 16'd3}, 5'd14, 1'b0, '0},
      '{'{CMD_ADD, 32'd200, 32'd7, 32'd6, 16'd4}, 5'd1, 1'b1,
        '{STATUS_FULL, 32'd0, 16'd0, 32'd0, 5'd16}},
      '{'{CMD_POP, 32'd0, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b1,
        '{STATUS_NONE, 32'd0, 16'd0, 32'd0, 5'd16}},
      '{'{CMD_REMOVE, 32'd0, 32'd0, 32'd6, 16'd0}, 5'd1, 1'b0, '0},
      // latest possible time: the saturated alarm still never expires
      '{'{CMD_POP, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b1,
        '{STATUS_DONE, 32'd2, 16'd2, 32'd100, 5'd1}},
      '{'{CMD_POP, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0}, 5'd1, 1'b1,
        '{STATUS_NONE, 32'd0, 16'd0, 32'd0, 5'd1}},
      '{'{CMD_CANCEL, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF}, 5'd1, 1'b1,
        '{STATUS_DONE, 32'hFFFF_FFFF, 16'd0, 32'd0, 5'd0}}
   };

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata  = '0;    // now[31:0], delay[63:32], session[95:64], alarm_id[111:96]
   logic [1:0]   req_tuser  = '0;    // cmd[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;          // out_session[31:0], out_alarm[47:32], out_expiry[79:48],
                                     // entries_held[84:80], zero pad[87:85]
   logic [1:0]   rsp_tuser;          // status[1:0]

   logic         quiet_tail = 1'b0;  // set for the last stretch: no idling on either side

   // Shadow of the sorted table, kept in step with accepted requests.
   logic [31:0]  tbl_expiry  [CAPACITY];
   logic [31:0]  tbl_session [CAPACITY];
   logic [15:0]  tbl_alarm   [CAPACITY];
   int           held_count = 0;
   logic [31:0]  timebase   = 32'd0;

   alarm_result_type pending_results[$];
   alarm_result_type observed;
   alarm_result_type wanted;
   int               failures = 0;

   sorted_alarm_timer_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // Close the gap behind a removed slot and shrink the table by one.
   function automatic void drop_alarm_slot(input int pos);
      int i;
      for (i = pos; i + 1 < held_count; i++) begin
         tbl_expiry[i]  = tbl_expiry[i + 1];
         tbl_session[i] = tbl_session[i + 1];
         tbl_alarm[i]   = tbl_alarm[i + 1];
      end
      if (held_count > 0)
         held_count--;
   endfunction

   // Apply one accepted request to the shadow table and work out its response.
   function automatic void advance_alarm_table(input alarm_request_type item,
                                               output alarm_result_type result);
      logic [32:0] sum;
      logic [31:0] due;
      int          pos;
      int          keep;
      int          i;
      bit          hit;
      result        = '0;
      result.status = STATUS_DONE;
      case (item.cmd)
         CMD_ADD: begin
            if (held_count >= CAPACITY) begin
               result.status = STATUS_FULL;
            end else begin
               sum = {1'b0, item.now} + {1'b0, item.delay};
               due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               pos = 0;
               while (pos < held_count && tbl_expiry[pos] < due)
                  pos++;
               // a tie with the head lands just behind it
               if (pos == 0 && held_count > 0 && tbl_expiry[0] == due)
                  pos = 1;
               for (i = held_count; i > pos; i--) begin
                  tbl_expiry[i]  = tbl_expiry[i - 1];
                  tbl_session[i] = tbl_session[i - 1];
                  tbl_alarm[i]   = tbl_alarm[i - 1];
               end
               tbl_expiry[pos]  = due;
               tbl_session[pos] = item.session;
               tbl_alarm[pos]   = item.alarm;
               held_count++;
            end
         end
         CMD_CANCEL: begin
            result.status = STATUS_NONE;
            hit = 1'b0;
            for (i = 0; i < held_count && !hit; i++) begin
               if (tbl_session[i] == item.session && tbl_alarm[i] == item.alarm) begin
                  result.status  = STATUS_DONE;
                  result.session = tbl_session[i];
                  drop_alarm_slot(i);
                  hit = 1'b1;
               end
            end
         end
         CMD_POP: begin
            if (held_count > 0 && tbl_expiry[0] < item.now) begin
               result.session = tbl_session[0];
               result.alarm   = tbl_alarm[0];
               result.expiry  = tbl_expiry[0];
               drop_alarm_slot(0);
            end else begin
               result.status = STATUS_NONE;
            end
         end
         default: begin
            keep = 0;
            for (i = 0; i < held_count; i++) begin
               if (tbl_session[i] != item.session) begin
                  tbl_expiry[keep]  = tbl_expiry[i];
                  tbl_session[keep] = tbl_session[i];
                  tbl_alarm[keep]   = tbl_alarm[i];
                  keep++;
               end
            end
            held_count = keep;
         end
      endcase
      result.held = held_count[CNT_W-1:0];
   endfunction

   // Random request shaped by the current table: cancels and removals mostly hit stored
   // alarms, pops often land right at or just past the head expiry. The command mix
   // cycles through fill, balanced and drain phases so the table both fills and empties.
   function automatic alarm_request_type random_alarm_request(input int unsigned serial);
      alarm_request_type item;
      int unsigned       roll;
      int unsigned       add_weight;
      int                pick;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         timebase = $urandom;
      else if (roll < 6)
         timebase = 32'hFFFF_FFFF - $urandom_range(0, 300);
      else
         timebase = timebase + $urandom_range(0, 40);

      case ((serial / 64) % 3)
         0:       add_weight = 70;
         1:       add_weight = 40;
         default: add_weight = 15;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < add_weight) begin
         item.cmd = CMD_ADD;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 35)
            item.cmd = CMD_CANCEL;
         else if (roll < 80)
            item.cmd = CMD_POP;
         else
            item.cmd = CMD_REMOVE;
      end

      roll = $urandom_range(0, 99);
      if (roll < 5)
         item.delay = $urandom;
      else if (roll < 8)
         item.delay = 32'hFFFF_FFFF;
      else if (roll < 15)
         item.delay = 32'd0;
      else
         item.delay = $urandom_range(0, 200);
      item.session = ($urandom_range(0, 99) < 5) ? $urandom : $urandom_range(0, 5);
      item.alarm   = ($urandom_range(0, 99) < 5) ? 16'($urandom) : 16'($urandom_range(0, 7));

      // aim cancels and removals at stored alarms
      if ((item.cmd == CMD_CANCEL || item.cmd == CMD_REMOVE) && held_count > 0
          && $urandom_range(0, 99) < 75) begin
         pick         = $urandom_range(0, held_count - 1);
         item.session = tbl_session[pick];
         item.alarm   = tbl_alarm[pick];
      end
      // walk the clock up to the head expiry: on it, or one or two ticks past
      if (item.cmd == CMD_POP && held_count > 0 && $urandom_range(0, 1) == 1)
         timebase = tbl_expiry[0] + $urandom_range(0, 2);
      item.now = timebase;
      return item;
   endfunction

   // Offer one request and hold it until the block takes it. Idle bursts come first.
   task automatic send_request(input alarm_request_type item, input bit allow_idle);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.cmd;
      req_tdata  <= {item.alarm, item.session, item.delay, item.now};
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   // Stimulus: reset, directed table, random traffic, then drain and report.
   initial begin : stimulus
      alarm_request_type item;
      alarm_result_type  predicted;
      int                r;
      int                serial;
      int                waited;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < DIRECTED_COUNT; r++) begin
         repeat (DIRECTED_ROWS[r].copies) begin
            send_request(DIRECTED_ROWS[r].request, 1'b1);
            advance_alarm_table(DIRECTED_ROWS[r].request, predicted);
            if (DIRECTED_ROWS[r].typed)
               predicted = DIRECTED_ROWS[r].result;
            pending_results.push_back(predicted);
         end
      end

      for (serial = 0; serial < RANDOM_ITEMS; serial++) begin
         quiet_tail <= (serial >= RANDOM_ITEMS - QUIET_ITEMS);
         item = random_alarm_request(serial);
         // idle only in two of every three stretches of 128 items, and never at the tail
         send_request(item, serial < RANDOM_ITEMS - QUIET_ITEMS && (serial / 128) % 3 != 0);
         advance_alarm_table(item, predicted);
         pending_results.push_back(predicted);
      end
      req_tvalid <= 1'b0;

      // let the responses drain, then give a last scan time to show a stray result
      for (waited = 0; pending_results.size() != 0 && waited < DRAIN_LIMIT; waited++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         failures++;
         $display("%0t: %0d responses never arrived", $time, pending_results.size());
      end
      if (failures == 0)
         $display("tb_sorted_alarm_timer_queue passed");
      else
         $display("tb_sorted_alarm_timer_queue failed");
      $finish;
   end

   // Receiver pacing: short random stalls in some stretches, one long hold-off that backs
   // the block up into its request channel, and no stalls at the tail of the run.
   initial begin : rsp_pacing
      int unsigned tick;
      int unsigned gap;
      bit          long_hold_done;
      tick           = 0;
      long_hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         tick++;
         if (!long_hold_done && tick >= LONG_HOLD_AT) begin
            gap            = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (!quiet_tail && (tick / 200) % 3 != 0 && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
         end else begin
            gap = 0;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            tick += gap;
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare each response transaction with the oldest pending result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.status  = status_type'(rsp_tuser);
         observed.session = rsp_tdata[31:0];
         observed.alarm   = rsp_tdata[47:32];
         observed.expiry  = rsp_tdata[79:48];
         observed.held    = rsp_tdata[84:80];
         if (pending_results.size() == 0) begin
            failures++;
            $display("%0t: response with nothing pending, expected none, actual %h",
                     $time, observed);
         end else begin
            wanted = pending_results.pop_front();
            compare_field("status", 32'(wanted.status), 32'(observed.status));
            compare_field("out_session", wanted.session, observed.session);
            compare_field("out_alarm", 32'(wanted.alarm), 32'(observed.alarm));
            compare_field("out_expiry", wanted.expiry, observed.expiry);
            compare_field("entries_held", 32'(wanted.held), 32'(observed.held));
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("%0t: timeout", $time);
      $display("tb_sorted_alarm_timer_queue failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/satq_pkg.sv
rtl/satq_cell.sv
rtl/sorted_alarm_timer_queue.sv
rtl/satq_checker.sv
dv/tb_sorted_alarm_timer_queue.sv
